// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros for the hdlc receiver, sampled on clk with rst_n low
// disabling the check. Defining NO_ASSERTIONS turns them into nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define HDLC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HDLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define HDLC_ASSERT_IMPLY(lbl, ante, cons, msg)
`define HDLC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: src/hdlc_rx_pkg.sv
// ----------------------------------------------------------------------------
// hdlc_rx_pkg
// Shared types, codes and the X.25 CRC byte step of the hdlc receiver.
// ----------------------------------------------------------------------------
package hdlc_rx_pkg;

  localparam int LENGTH_BITS_DEF = 11;

  localparam int BYTE_W    = 8;
  localparam int COUNT_W   = 11;
  localparam int FORMAT_W  = 16;
  localparam int CRC_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int SEG_BIT   = 11;

  localparam logic [BYTE_W-1:0]  START_FLAG    = 8'h7E;
  localparam logic [BYTE_W-1:0]  CFG_RESET_VAL = 8'hFF;
  localparam logic [CRC_W-1:0]   CRC_INIT      = 16'hFFFF;
  localparam logic [CRC_W-1:0]   CRC_POLY_REFL = 16'h8408;
  localparam logic [CRC_W-1:0]   GOOD_RESIDUE  = 16'hF0B8;
  localparam logic [COUNT_W-1:0] MAX_COUNT     = 11'h7FF;

  localparam logic [CFG_IDX_W-1:0] REG_IDENT_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IDENT_B = 2'd1;

  typedef enum logic [2:0] {
    STAT_NEED_MORE  = 3'd0,
    STAT_SUCCESS    = 3'd1,
    STAT_ID_MISMATCH = 3'd2,
    STAT_HCS_FAIL   = 3'd3,
    STAT_FCS_FAIL   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    KIND_NONE      = 2'd0,
    KIND_FRAME     = 2'd1,
    KIND_IDENT_REQ = 2'd2,
    KIND_IDENT_RSP = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ROLE_IGNORED = 4'd0,
    ROLE_FORMAT  = 4'd1,
    ROLE_DEST    = 4'd2,
    ROLE_SRC     = 4'd3,
    ROLE_CONTROL = 4'd4,
    ROLE_HCS     = 4'd5,
    ROLE_INFO    = 4'd6,
    ROLE_FCS     = 4'd7,
    ROLE_IDENT   = 4'd8
  } role_t;

  typedef struct packed {
    logic [BYTE_W-1:0] ident_a;
    logic [BYTE_W-1:0] ident_b;
  } cfg_t;

  typedef struct packed {
    status_t            status;
    kind_t              frame_kind;
    role_t              byte_role;
    logic [BYTE_W-1:0]  byte_value;
    logic [COUNT_W-1:0] info_length;
    logic               segmented;
  } result_t;

  // identify response 00 04 01 00
  function automatic logic [BYTE_W-1:0] ident_resp_byte(input logic [1:0] idx);
    logic [BYTE_W-1:0] val;
    case (idx)
      2'd1:    val = 8'h04;
      2'd2:    val = 8'h01;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

  // reflected crc-16, lsb first
  function automatic logic [CRC_W-1:0] crc_x25_byte(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: src/hdlc_rx_parser.sv
// ----------------------------------------------------------------------------
// hdlc_rx_parser
// Frame parse state, counters and running crc. Produces the result for the
// byte presented and advances its state when step is high.
// ----------------------------------------------------------------------------
module hdlc_rx_parser #(
  parameter int LENGTH_BITS = hdlc_rx_pkg::LENGTH_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step,
  input  logic [hdlc_rx_pkg::BYTE_W-1:0]  rx_byte,
  input  hdlc_rx_pkg::cfg_t               cfg,
  output hdlc_rx_pkg::result_t            res
);

  localparam int CW = hdlc_rx_pkg::COUNT_W;
  localparam int FW = hdlc_rx_pkg::FORMAT_W;
  localparam int DW = FW + 1;

  typedef enum logic [3:0] {
    PS_IDLE, PS_IDENT, PS_FORMAT, PS_DEST, PS_SRC, PS_CONTROL, PS_HCS, PS_INFO, PS_FCS
  } pstate_t;

  pstate_t                    state_r, state_nxt;
  logic [2:0]                 fcnt_r, fcnt_nxt;
  logic [CW-1:0]              bcnt_r, bcnt_nxt;
  logic [CW-1:0]              hcnt_r, hcnt_nxt;
  logic [FW-1:0]              fmt_r, fmt_nxt;
  logic [hdlc_rx_pkg::CRC_W-1:0] crc_r, crc_nxt;
  logic                       id_ok_r, id_ok_nxt;
  logic [CW-1:0]              ilen_r, ilen_nxt;

  logic [hdlc_rx_pkg::CRC_W-1:0] crc_upd;
  logic [CW-1:0]              hcnt_inc;
  logic [CW-1:0]              bcnt_inc;
  logic [2:0]                 fcnt_cl;
  logic [LENGTH_BITS-1:0]     len_bits;
  logic [DW-1:0]              len_ext;
  logic [DW-1:0]              need_ext;
  logic [DW-1:0]              diff;
  logic [CW-1:0]              info_cnt;
  logic                       done;
  logic                       seg_sel;

  hdlc_rx_pkg::status_t       status;
  hdlc_rx_pkg::kind_t         kind;
  hdlc_rx_pkg::role_t         role;
  logic [CW-1:0]              ilen;

  assign crc_upd  = hdlc_rx_pkg::crc_x25_byte(crc_r, rx_byte);
  assign hcnt_inc = (hcnt_r == hdlc_rx_pkg::MAX_COUNT) ? hcnt_r : hcnt_r + 1'b1;
  assign bcnt_inc = (bcnt_r == hdlc_rx_pkg::MAX_COUNT) ? bcnt_r : bcnt_r + 1'b1;
  assign fcnt_cl  = (fcnt_r > 3'd3) ? 3'd3 : fcnt_r;

  // info count after the last header byte: length - header bytes - 2, clamped
  assign len_bits = fmt_r[LENGTH_BITS-1:0];
  assign len_ext  = DW'(len_bits);
  assign need_ext = DW'(hcnt_inc) + DW'(2);
  assign diff     = len_ext - need_ext;
  always_comb begin
    if (len_ext <= need_ext) begin
      info_cnt = '0;
    end else if (diff > DW'(hdlc_rx_pkg::MAX_COUNT)) begin
      info_cnt = hdlc_rx_pkg::MAX_COUNT;
    end else begin
      info_cnt = diff[CW-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    fcnt_nxt  = fcnt_r;
    bcnt_nxt  = bcnt_r;
    hcnt_nxt  = hcnt_r;
    fmt_nxt   = fmt_r;
    crc_nxt   = crc_r;
    id_ok_nxt = id_ok_r;
    ilen_nxt  = ilen_r;
    status    = hdlc_rx_pkg::STAT_NEED_MORE;
    kind      = hdlc_rx_pkg::KIND_NONE;
    role      = hdlc_rx_pkg::ROLE_IGNORED;
    ilen      = '0;
    done      = 1'b0;
    seg_sel   = 1'b0;

    case (state_r)
      PS_IDLE: begin
        if (rx_byte == hdlc_rx_pkg::START_FLAG) begin
          state_nxt = PS_FORMAT;
          fcnt_nxt  = '0;
          bcnt_nxt  = '0;
          hcnt_nxt  = '0;
          fmt_nxt   = '0;
          crc_nxt   = hdlc_rx_pkg::CRC_INIT;
          kind      = hdlc_rx_pkg::KIND_FRAME;
        end else if (rx_byte == cfg.ident_a || rx_byte == cfg.ident_b) begin
          status = hdlc_rx_pkg::STAT_SUCCESS;
          kind   = hdlc_rx_pkg::KIND_IDENT_REQ;
          role   = hdlc_rx_pkg::ROLE_IDENT;
        end else if (rx_byte == hdlc_rx_pkg::ident_resp_byte(2'd0)) begin
          state_nxt = PS_IDENT;
          fcnt_nxt  = 3'd1;
          id_ok_nxt = 1'b1;
          kind      = hdlc_rx_pkg::KIND_IDENT_RSP;
          role      = hdlc_rx_pkg::ROLE_IDENT;
        end
      end
      PS_IDENT: begin
        kind      = hdlc_rx_pkg::KIND_IDENT_RSP;
        role      = hdlc_rx_pkg::ROLE_IDENT;
        id_ok_nxt = id_ok_r && (rx_byte == hdlc_rx_pkg::ident_resp_byte(fcnt_cl[1:0]));
        fcnt_nxt  = fcnt_cl + 3'd1;
        if (fcnt_cl == 3'd3) begin
          status = id_ok_nxt ? hdlc_rx_pkg::STAT_SUCCESS : hdlc_rx_pkg::STAT_ID_MISMATCH;
          done   = 1'b1;
        end
      end
      PS_FORMAT: begin
        kind     = hdlc_rx_pkg::KIND_FRAME;
        role     = hdlc_rx_pkg::ROLE_FORMAT;
        crc_nxt  = crc_upd;
        hcnt_nxt = hcnt_inc;
        fmt_nxt  = {fmt_r[FW-9:0], rx_byte};
        if (fcnt_r >= 3'd1) begin
          fcnt_nxt  = '0;
          state_nxt = PS_DEST;
          seg_sel   = 1'b1;
        end else begin
          fcnt_nxt = fcnt_r + 3'd1;
        end
      end
      PS_DEST: begin
        kind     = hdlc_rx_pkg::KIND_FRAME;
        role     = hdlc_rx_pkg::ROLE_DEST;
        crc_nxt  = crc_upd;
        hcnt_nxt = hcnt_inc;
        seg_sel  = 1'b1;
        if (rx_byte[0]) begin
          state_nxt = PS_SRC;
        end
      end
      PS_SRC: begin
        kind     = hdlc_rx_pkg::KIND_FRAME;
        role     = hdlc_rx_pkg::ROLE_SRC;
        crc_nxt  = crc_upd;
        hcnt_nxt = hcnt_inc;
        seg_sel  = 1'b1;
        if (rx_byte[0]) begin
          state_nxt = PS_CONTROL;
        end
      end
      PS_CONTROL: begin
        kind      = hdlc_rx_pkg::KIND_FRAME;
        role      = hdlc_rx_pkg::ROLE_CONTROL;
        crc_nxt   = crc_upd;
        hcnt_nxt  = hcnt_inc;
        seg_sel   = 1'b1;
        fcnt_nxt  = '0;
        state_nxt = PS_HCS;
      end
      PS_HCS: begin
        kind     = hdlc_rx_pkg::KIND_FRAME;
        role     = hdlc_rx_pkg::ROLE_HCS;
        crc_nxt  = crc_upd;
        hcnt_nxt = hcnt_inc;
        seg_sel  = 1'b1;
        if (fcnt_r >= 3'd1) begin
          fcnt_nxt = '0;
          bcnt_nxt = '0;
          ilen     = info_cnt;
          ilen_nxt = info_cnt;
          if (crc_upd != hdlc_rx_pkg::GOOD_RESIDUE) begin
            status = hdlc_rx_pkg::STAT_HCS_FAIL;
            done   = 1'b1;
          end else if (info_cnt == '0) begin
            // header only, no frame check follows
            status = hdlc_rx_pkg::STAT_SUCCESS;
            done   = 1'b1;
          end else begin
            state_nxt = PS_INFO;
          end
        end else begin
          fcnt_nxt = fcnt_r + 3'd1;
        end
      end
      PS_INFO: begin
        kind     = hdlc_rx_pkg::KIND_FRAME;
        role     = hdlc_rx_pkg::ROLE_INFO;
        crc_nxt  = crc_upd;
        ilen     = ilen_r;
        seg_sel  = 1'b1;
        bcnt_nxt = bcnt_inc;
        if (bcnt_inc >= ilen_r) begin
          fcnt_nxt  = '0;
          state_nxt = PS_FCS;
        end
      end
      PS_FCS: begin
        kind    = hdlc_rx_pkg::KIND_FRAME;
        role    = hdlc_rx_pkg::ROLE_FCS;
        crc_nxt = crc_upd;
        ilen    = ilen_r;
        seg_sel = 1'b1;
        if (fcnt_r >= 3'd1) begin
          status = (crc_upd == hdlc_rx_pkg::GOOD_RESIDUE) ?
                   hdlc_rx_pkg::STAT_SUCCESS : hdlc_rx_pkg::STAT_FCS_FAIL;
          done   = 1'b1;
        end else begin
          fcnt_nxt = fcnt_r + 3'd1;
        end
      end
      default: begin
        state_nxt = PS_IDLE;
      end
    endcase

    if (done) begin
      state_nxt = PS_IDLE;
      fcnt_nxt  = '0;
    end
  end

  always_comb begin
    res.status      = status;
    res.frame_kind  = kind;
    res.byte_role   = role;
    res.byte_value  = rx_byte;
    res.info_length = ilen;
    res.segmented   = seg_sel & fmt_nxt[hdlc_rx_pkg::SEG_BIT];
  end

  // ilen_r is only read in the info and frame check states
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PS_IDLE;
      fcnt_r  <= '0;
      bcnt_r  <= '0;
      hcnt_r  <= '0;
      fmt_r   <= '0;
      crc_r   <= hdlc_rx_pkg::CRC_INIT;
      id_ok_r <= 1'b1;
      ilen_r  <= '0;
    end else if (step) begin
      state_r <= state_nxt;
      fcnt_r  <= fcnt_nxt;
      bcnt_r  <= bcnt_nxt;
      hcnt_r  <= hcnt_nxt;
      fmt_r   <= fmt_nxt;
      crc_r   <= crc_nxt;
      id_ok_r <= id_ok_nxt;
      ilen_r  <= ilen_nxt;
    end
  end

endmodule

// File: src/hdlc_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// hdlc_frame_receiver_unit
// Byte-serial hdlc receiver: flag hunt, identify request and response
// detection, header and frame parsing with crc-16/x.25 checks.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------
//   in_     | input     | in_valid / in_stall | in_rx_byte
//   out_    | output    | out_valid/out_stall | status, frame_kind, byte_role,
//           |           |                     | byte_value, info_length, segmented
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One byte per cycle sustained while out_stall is low. An accepted byte is
// held in the input register, then parsed into the result register, which
// raises out_valid; the crc byte step and the info count subtract set the path.
// rst_n (synchronous) returns the parser to flag hunt and both identify
// bytes to 0xff. A stalled result holds; one more byte waits in the input
// register before in_stall rises. cfg_ready is always high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hdlc_frame_receiver_unit #(
  parameter int LENGTH_BITS = hdlc_rx_pkg::LENGTH_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [hdlc_rx_pkg::BYTE_W-1:0]      in_rx_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_status,
  output logic [1:0]                          out_frame_kind,
  output logic [3:0]                          out_byte_role,
  output logic [hdlc_rx_pkg::BYTE_W-1:0]      out_byte_value,
  output logic [hdlc_rx_pkg::COUNT_W-1:0]     out_info_length,
  output logic                                out_segmented,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hdlc_rx_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hdlc_rx_pkg::BYTE_W-1:0]      cfg_data
);

  logic                              in_v_r;
  logic [hdlc_rx_pkg::BYTE_W-1:0]    in_byte_r;
  logic                              out_v_r;
  hdlc_rx_pkg::result_t              res_r;
  hdlc_rx_pkg::result_t              res;
  hdlc_rx_pkg::cfg_t                 cfg_r;
  logic                              accept;
  logic                              advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ident_a <= hdlc_rx_pkg::CFG_RESET_VAL;
      cfg_r.ident_b <= hdlc_rx_pkg::CFG_RESET_VAL;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hdlc_rx_pkg::REG_IDENT_A: cfg_r.ident_a <= cfg_data;
        hdlc_rx_pkg::REG_IDENT_B: cfg_r.ident_b <= cfg_data;
        default: ;
      endcase
    end
  end

  // the held byte moves on whenever the result register is free or draining
  assign advance  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && out_v_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (accept) begin
        in_v_r <= 1'b1;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_v_r && !out_stall) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_rx_byte;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  hdlc_rx_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  assign out_valid       = out_v_r;
  assign out_status      = res_r.status;
  assign out_frame_kind  = res_r.frame_kind;
  assign out_byte_role   = res_r.byte_role;
  assign out_byte_value  = res_r.byte_value;
  assign out_info_length = res_r.info_length;
  assign out_segmented   = res_r.segmented;

  `HDLC_ASSERT_IMPLY(a_hcs_fail_role,
    out_valid && out_status == hdlc_rx_pkg::STAT_HCS_FAIL,
    out_byte_role == hdlc_rx_pkg::ROLE_HCS && out_frame_kind == hdlc_rx_pkg::KIND_FRAME,
    "header check failure on a non-hcs byte")
  `HDLC_ASSERT_IMPLY(a_idle_byte_quiet,
    out_valid && out_frame_kind == hdlc_rx_pkg::KIND_NONE,
    out_status == hdlc_rx_pkg::STAT_NEED_MORE && out_byte_role == hdlc_rx_pkg::ROLE_IGNORED,
    "unclaimed byte carries a status or role")
  `HDLC_ASSERT_NEXT(a_held_byte_kept, in_v_r && !advance,
    in_v_r && $stable(in_byte_r), "waiting input byte lost")
  `HDLC_ASSERT_NEXT(a_result_loaded, advance, out_v_r, "parsed byte produced no result")

endmodule

// File: bench/hdlc_frame_receiver_unit_tb.sv
// ----------------------------------------------------------------------------
// hdlc_frame_receiver_unit_tb
// Drives received bytes into the hdlc receiver and predicts every result
// from a behavioral copy of the parser: flag hunt, identify requests and
// responses, header and frame parsing with running x.25 crc checks. Stimulus
// is mostly well-formed frames with random content, plus broken frames,
// identify traffic and noise, under several identify byte settings.
// ----------------------------------------------------------------------------
module hdlc_frame_receiver_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [3:0] {
    PH_HUNT,
    PH_IDENT,
    PH_FORMAT,
    PH_DEST,
    PH_SRC,
    PH_CONTROL,
    PH_HCS,
    PH_INFO,
    PH_FCS
  } parse_phase_t;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int PHASE_BYTES   = 220;
  localparam int DRAIN_CYCLES  = 8;

  // indexes past the two identify registers, written to see them ignored
  localparam logic [hdlc_rx_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [hdlc_rx_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  localparam logic [7:0] IDENT_RSP [4] = '{8'h00, 8'h04, 8'h01, 8'h00};

  class frame_parse_tracker;
    hdlc_rx_pkg::result_t expected_results[$];
    int           error_count;
    parse_phase_t phase;
    logic [10:0]  field_cnt;
    logic [10:0]  info_cnt;
    logic [10:0]  hdr_cnt;
    logic [15:0]  format_word;
    logic [15:0]  crc;
    logic         ident_ok;
    logic [7:0]   ident_a;
    logic [7:0]   ident_b;

    function new();
      error_count = 0;
      phase       = PH_HUNT;
      field_cnt   = '0;
      info_cnt    = '0;
      hdr_cnt     = '0;
      format_word = '0;
      crc         = 16'hFFFF;
      ident_ok    = 1'b1;
      ident_a     = 8'hFF;
      ident_b     = 8'hFF;
    endfunction

    static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
        r = r[0] ? ((r >> 1) ^ hdlc_rx_pkg::CRC_POLY_REFL) : (r >> 1);
      end
      return r;
    endfunction

    function void set_reg(logic [hdlc_rx_pkg::CFG_IDX_W-1:0] idx, logic [7:0] v);
      case (idx)
        hdlc_rx_pkg::REG_IDENT_A: ident_a = v;
        hdlc_rx_pkg::REG_IDENT_B: ident_b = v;
        default: ;
      endcase
    endfunction

    // length minus header bytes minus the two fcs bytes, floored at zero and capped at MAX_COUNT
    function logic [10:0] info_len();
      int len;
      int need;
      len  = int'(format_word[10:0]);
      need = int'(hdr_cnt) + 2;
      if (len <= need) return '0;
      return (len - need > int'(hdlc_rx_pkg::MAX_COUNT)) ?
             hdlc_rx_pkg::MAX_COUNT : 11'(len - need);
    endfunction

    function void add_header(logic [7:0] b);
      crc = crc_step(crc, b);
      if (hdr_cnt < hdlc_rx_pkg::MAX_COUNT) hdr_cnt++;
    endfunction

    function void take_byte(logic [7:0] b);
      hdlc_rx_pkg::result_t r;
      bit      done;
      r.status      = hdlc_rx_pkg::STAT_NEED_MORE;
      r.frame_kind  = hdlc_rx_pkg::KIND_NONE;
      r.byte_role   = hdlc_rx_pkg::ROLE_IGNORED;
      r.byte_value  = b;
      r.info_length = '0;
      r.segmented   = 1'b0;
      done          = 1'b0;
      case (phase)
        PH_HUNT: begin
          if (b == hdlc_rx_pkg::START_FLAG) begin
            phase       = PH_FORMAT;
            field_cnt   = '0;
            info_cnt    = '0;
            hdr_cnt     = '0;
            format_word = '0;
            crc         = 16'hFFFF;
            r.frame_kind = hdlc_rx_pkg::KIND_FRAME;
          end else if (b == ident_a || b == ident_b) begin
            r.status     = hdlc_rx_pkg::STAT_SUCCESS;
            r.frame_kind = hdlc_rx_pkg::KIND_IDENT_REQ;
            r.byte_role  = hdlc_rx_pkg::ROLE_IDENT;
          end else if (b == IDENT_RSP[0]) begin
            phase        = PH_IDENT;
            field_cnt    = 11'd1;
            ident_ok     = 1'b1;
            r.frame_kind = hdlc_rx_pkg::KIND_IDENT_RSP;
            r.byte_role  = hdlc_rx_pkg::ROLE_IDENT;
          end
        end
        PH_IDENT: begin
          r.frame_kind = hdlc_rx_pkg::KIND_IDENT_RSP;
          r.byte_role  = hdlc_rx_pkg::ROLE_IDENT;
          if (field_cnt > 3) field_cnt = 11'd3;
          if (b != IDENT_RSP[field_cnt[1:0]]) ident_ok = 1'b0;
          field_cnt++;
          if (field_cnt >= 4) begin
            r.status = ident_ok ? hdlc_rx_pkg::STAT_SUCCESS : hdlc_rx_pkg::STAT_ID_MISMATCH;
            done     = 1'b1;
          end
        end
        PH_FORMAT: begin
          r.frame_kind = hdlc_rx_pkg::KIND_FRAME;
          r.byte_role  = hdlc_rx_pkg::ROLE_FORMAT;
          add_header(b);
          format_word = {format_word[7:0], b};
          field_cnt++;
          if (field_cnt >= 2) begin
            field_cnt = '0;
            phase     = PH_DEST;
          end
        end
        PH_DEST: begin
          r.frame_kind = hdlc_rx_pkg::KIND_FRAME;
          r.byte_role  = hdlc_rx_pkg::ROLE_DEST;
          add_header(b);
          if (b[0]) phase = PH_SRC;
        end
        PH_SRC: begin
          r.frame_kind = hdlc_rx_pkg::KIND_FRAME;
          r.byte_role  = hdlc_rx_pkg::ROLE_SRC;
          add_header(b);
          if (b[0]) phase = PH_CONTROL;
        end
        PH_CONTROL: begin
          r.frame_kind = hdlc_rx_pkg::KIND_FRAME;
          r.byte_role  = hdlc_rx_pkg::ROLE_CONTROL;
          add_header(b);
          field_cnt = '0;
          phase     = PH_HCS;
        end
        PH_HCS: begin
          r.frame_kind = hdlc_rx_pkg::KIND_FRAME;
          r.byte_role  = hdlc_rx_pkg::ROLE_HCS;
          add_header(b);
          field_cnt++;
          if (field_cnt >= 2) begin
            field_cnt = '0;
            info_cnt  = '0;
            if (crc != hdlc_rx_pkg::GOOD_RESIDUE) begin
              r.status = hdlc_rx_pkg::STAT_HCS_FAIL;
              done     = 1'b1;
            end else if (info_len() == 0) begin
              // nothing to carry: the frame ends on the header check
              r.status = hdlc_rx_pkg::STAT_SUCCESS;
              done     = 1'b1;
            end else begin
              phase = PH_INFO;
            end
            r.info_length = info_len();
          end
        end
        PH_INFO: begin
          r.frame_kind  = hdlc_rx_pkg::KIND_FRAME;
          r.byte_role   = hdlc_rx_pkg::ROLE_INFO;
          crc           = crc_step(crc, b);
          r.info_length = info_len();
          if (info_cnt < hdlc_rx_pkg::MAX_COUNT) info_cnt++;
          if (info_cnt >= r.info_length) begin
            field_cnt = '0;
            phase     = PH_FCS;
          end
        end
        PH_FCS: begin
          r.frame_kind  = hdlc_rx_pkg::KIND_FRAME;
          r.byte_role   = hdlc_rx_pkg::ROLE_FCS;
          crc           = crc_step(crc, b);
          r.info_length = info_len();
          field_cnt++;
          if (field_cnt >= 2) begin
            r.status = (crc == hdlc_rx_pkg::GOOD_RESIDUE) ?
                       hdlc_rx_pkg::STAT_SUCCESS : hdlc_rx_pkg::STAT_FCS_FAIL;
            done     = 1'b1;
          end
        end
        default: phase = PH_HUNT;
      endcase
      if (r.frame_kind == hdlc_rx_pkg::KIND_FRAME && (phase >= PH_DEST || done))
        r.segmented = format_word[hdlc_rx_pkg::SEG_BIT];
      if (done) begin
        phase     = PH_HUNT;
        field_cnt = '0;
      end
      expected_results.push_back(r);
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void report(string what, logic [15:0] want, logic [15:0] got);
      error_count++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void check_result(hdlc_rx_pkg::result_t got);
      hdlc_rx_pkg::result_t want;
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: result with no request pending: expected none, got byte %0h",
                 $time, got.byte_value);
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status) report("status", want.status, got.status);
      if (got.frame_kind !== want.frame_kind)
        report("frame_kind", want.frame_kind, got.frame_kind);
      if (got.byte_role !== want.byte_role)
        report("byte_role", want.byte_role, got.byte_role);
      if (got.byte_value !== want.byte_value)
        report("byte_value", want.byte_value, got.byte_value);
      if (got.info_length !== want.info_length)
        report("info_length", want.info_length, got.info_length);
      if (got.segmented !== want.segmented)
        report("segmented", want.segmented, got.segmented);
    endfunction
  endclass

  logic                                clk;
  logic                                rst_n;
  logic                                in_valid;
  logic                                in_stall;
  logic [hdlc_rx_pkg::BYTE_W-1:0]      in_rx_byte;
  logic                                out_valid;
  logic                                out_stall;
  logic [2:0]                          out_status;
  logic [1:0]                          out_frame_kind;
  logic [3:0]                          out_byte_role;
  logic [hdlc_rx_pkg::BYTE_W-1:0]      out_byte_value;
  logic [hdlc_rx_pkg::COUNT_W-1:0]     out_info_length;
  logic                                out_segmented;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [hdlc_rx_pkg::CFG_IDX_W-1:0]   cfg_index;
  logic [hdlc_rx_pkg::BYTE_W-1:0]      cfg_data;

  frame_parse_tracker tracker = new();
  int sender_pct;
  int recv_pct;
  int sent_bytes;

  hdlc_frame_receiver_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_frame_kind  (out_frame_kind),
    .out_byte_role   (out_byte_role),
    .out_byte_value  (out_byte_value),
    .out_info_length (out_info_length),
    .out_segmented   (out_segmented),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(99) < recv_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_result(hdlc_rx_pkg::result_t'{
        hdlc_rx_pkg::status_t'(out_status), hdlc_rx_pkg::kind_t'(out_frame_kind),
        hdlc_rx_pkg::role_t'(out_byte_role), out_byte_value,
        out_info_length, out_segmented});
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // callers chain these back to back, so valid stays up between requests unless a random gap is drawn
  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_pct) gap++;
    @(negedge clk);
    repeat (gap) begin
      in_valid   = 1'b0;
      in_rx_byte = 8'($urandom);
      @(negedge clk);
    end
    in_valid   = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (in_stall);
    tracker.take_byte(b);
    sent_bytes++;
  endtask

  task automatic send_frame(input int dest_n, input int src_n, input int info_n,
                            input int len_delta, input bit bad_hcs, input bit bad_fcs);
    logic [15:0] crc;
    logic [15:0] fmt;
    logic [15:0] chk;
    logic [7:0]  b;
    int          len;
    len = 2 + dest_n + src_n + 1 + 2 + info_n + 2 + len_delta;
    if (len < 0) len = 0;
    if (len > int'(hdlc_rx_pkg::MAX_COUNT)) len = int'(hdlc_rx_pkg::MAX_COUNT);
    fmt = {4'($urandom), 1'($urandom), 11'(len)};
    crc = 16'hFFFF;
    push_byte(hdlc_rx_pkg::START_FLAG);
    for (int i = 0; i < 3 + dest_n + src_n; i++) begin
      b = 8'($urandom);
      if (i == 0) b = fmt[15:8];
      else if (i == 1) b = fmt[7:0];
      else if (i < 2 + dest_n) b[0] = (i == 1 + dest_n);
      else if (i < 2 + dest_n + src_n) b[0] = (i == 1 + dest_n + src_n);
      push_byte(b);
      crc = frame_parse_tracker::crc_step(crc, b);
    end
    chk = ~crc;
    if (bad_hcs) chk ^= 16'($urandom_range(1, 65535));
    push_byte(chk[7:0]);
    crc = frame_parse_tracker::crc_step(crc, chk[7:0]);
    push_byte(chk[15:8]);
    crc = frame_parse_tracker::crc_step(crc, chk[15:8]);
    if (info_n > 0) begin
      repeat (info_n) begin
        b = 8'($urandom);
        push_byte(b);
        crc = frame_parse_tracker::crc_step(crc, b);
      end
      chk = ~crc;
      if (bad_fcs) chk ^= 16'($urandom_range(1, 65535));
      push_byte(chk[7:0]);
      push_byte(chk[15:8]);
    end
  endtask

  task automatic send_ident_rsp(input bit corrupt);
    logic [7:0] seq [4];
    seq = IDENT_RSP;
    if (corrupt) seq[$urandom_range(1, 3)] ^= 8'($urandom_range(1, 255));
    foreach (seq[i]) push_byte(seq[i]);
  endtask

  task automatic run_random(input int budget);
    int start;
    int r;
    int info_n;
    start = sent_bytes;
    while (sent_bytes - start < budget) begin
      r = $urandom_range(99);
      info_n = $urandom_range(99);
      if (info_n < 2) info_n = $urandom_range(60, 200);
      else if (info_n < 15) info_n = 0;
      else info_n = $urandom_range(1, 24);
      if (r < 55) begin
        send_frame($urandom_range(1, 4), $urandom_range(1, 3), info_n, 0, 1'b0, 1'b0);
      end else if (r < 62) begin
        send_frame($urandom_range(1, 3), $urandom_range(1, 3), info_n, 0, 1'b1, 1'b0);
      end else if (r < 70) begin
        send_frame($urandom_range(1, 3), $urandom_range(1, 3), info_n, 0, 1'b0, 1'b1);
      end else if (r < 75) begin
        // length field off by a few bytes: the parser loses step with the frame
        r = $urandom_range(1, 3);
        send_frame(1, 1, info_n, $urandom_range(1) ? r : -r, 1'b0, 1'b0);
      end else if (r < 83) begin
        send_ident_rsp($urandom_range(2) == 0);
      end else if (r < 89) begin
        push_byte($urandom_range(1) ? tracker.ident_a : tracker.ident_b);
      end else if (r < 95) begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
      end else begin
        // truncated frame
        push_byte(hdlc_rx_pkg::START_FLAG);
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
      end
    end
  endtask

  task automatic write_reg(input logic [hdlc_rx_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(idx, v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = '0;
    cfg_valid  = 1'b0;
    cfg_index  = hdlc_rx_pkg::REG_IDENT_A;
    cfg_data   = '0;
    sender_pct = 0;
    recv_pct   = 0;
    sent_bytes = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // identify request at reset value, good and failed identify responses,
    // a frame whose length is below the header size, a frame with one info byte
    push_byte(8'hFF);
    send_ident_rsp(1'b0);
    send_ident_rsp(1'b1);
    send_frame(1, 1, 0, -3, 1'b0, 1'b0);
    send_frame(1, 1, 1, 0, 1'b0, 1'b0);
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        1: begin
          // request value 0x00 shadows the response start, 0x7e loses to the flag
          write_reg(hdlc_rx_pkg::REG_IDENT_A, 8'h00);
          write_reg(hdlc_rx_pkg::REG_IDENT_B, hdlc_rx_pkg::START_FLAG);
        end
        2: begin
          write_reg(hdlc_rx_pkg::REG_IDENT_A, 8'($urandom));
          write_reg(hdlc_rx_pkg::REG_IDENT_B, 8'($urandom));
        end
        3: begin
          write_reg(REG_SPARE_LO, 8'($urandom));
          write_reg(REG_SPARE_HI, 8'($urandom));
          write_reg(hdlc_rx_pkg::REG_IDENT_A, 8'hFF);
          write_reg(hdlc_rx_pkg::REG_IDENT_B, 8'($urandom));
        end
        4: begin
          write_reg(hdlc_rx_pkg::REG_IDENT_A, 8'($urandom));
          write_reg(hdlc_rx_pkg::REG_IDENT_B, 8'h00);
        end
        5: begin
          write_reg(hdlc_rx_pkg::REG_IDENT_A, 8'($urandom));
          write_reg(hdlc_rx_pkg::REG_IDENT_B, 8'($urandom));
        end
        default: ;
      endcase
      sender_pct = (p < 2) ? 13 : (p < 4) ? 46 : 0;
      recv_pct   = (p < 2) ? 46 : (p < 4) ? 13 : 0;
      run_random(PHASE_BYTES);
      settle();
    end

    if (tracker.error_count == 0 && tracker.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
